// ===== rtl/pups_pkg.sv =====
// Shared types, constants and helpers for the profile unlock prefetch sequencer.
package pups_pkg;

  localparam logic [3:0] STATUS_POLLS  = 4'd6;
  localparam logic [7:0] HANDSHAKE_LEN = 8'd61;

  localparam logic [7:0] HANDSHAKE_RPT_ID = 8'h20;
  localparam logic [7:0] PROF_FIRST       = 8'h70;
  localparam logic [7:0] PROF_LAST        = 8'h7B;
  localparam logic [7:0] WRITE_FIRST      = 8'h60;
  localparam logic [7:0] WRITE_LAST       = 8'h62;
  localparam logic [7:0] STATUS_ID        = 8'h81;

  localparam logic [3:0] ROUND_REFETCH = STATUS_POLLS + 4'd1;
  localparam logic [3:0] ROUND_END     = STATUS_POLLS + 4'd2;

  typedef enum logic [2:0] {
    CMD_SEEN  = 3'd0,
    CMD_SET   = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_RESET = 3'd3,
    CMD_QUERY = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE      = 2'd0,
    ACT_HANDSHAKE = 2'd1,
    ACT_UNLOCK    = 2'd2,
    ACT_REQUEST   = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    REG_UNLOCK_WAIT   = 3'd0,
    REG_PF_INTERVAL   = 3'd1,
    REG_RESEND_DELAY  = 3'd2,
    REG_POLL_DELAY    = 3'd3,
    REG_POLL_INTERVAL = 3'd4,
    REG_REFETCH_DELAY = 3'd5,
    REG_PATHS         = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rpt_id;
    logic [7:0]  report_len;
    logic [31:0] now;
    logic [2:0]  transfer_ok;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] request_id;
    logic       edge_detected;
    logic       snap_ready;
    logic       nak_profile;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] unlock_wait;
    logic [15:0] pf_interval;
    logic [15:0] resend_delay;
    logic [15:0] poll_delay;
    logic [15:0] poll_interval;
    logic [15:0] refetch_delay;
    logic [1:0]  paths;
  } cfg_t;

  // All results of one item, handed from the engine to the output side.
  typedef struct packed {
    logic [1:0]            count;
    logic [2:0][1:0]       action;
    logic [2:0][7:0]       request_id;
    logic                  edge_detected;
    logic                  snap_ready;
    logic                  nak_profile;
  } bundle_t;

  typedef struct packed {
    logic        edge_flag;
    logic        ready_flag;
    logic        hs_valid;
    logic        unlock_armed;
    logic        unlock_wait;
    logic [31:0] unlock_dl;
    logic        pf_active;
    logic        pf_marks;
    logic [7:0]  pf_next_id;
    logic [31:0] pf_dl;
    logic        ps_active;
    logic [3:0]  ps_round;
    logic [31:0] ps_start;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    edge_flag:      1'b0,
    ready_flag:     1'b1,
    hs_valid:       1'b0,
    unlock_armed:   1'b0,
    unlock_wait:    1'b0,
    unlock_dl:      32'd0,
    pf_active:      1'b0,
    pf_marks:       1'b0,
    pf_next_id:     PROF_FIRST,
    pf_dl:          32'd0,
    ps_active:      1'b0,
    ps_round:       4'd0,
    ps_start:       32'd0
  };

  localparam cfg_t CFG_RESET = '{
    unlock_wait:   16'd4000,
    pf_interval:   16'd80,
    resend_delay:  16'd500,
    poll_delay:    16'd1000,
    poll_interval: 16'd250,
    refetch_delay: 16'd5500,
    paths:         2'd3
  };

  // A deadline is due once the wrapped difference is not negative.
  function automatic logic is_due(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return ~diff[31];
  endfunction

endpackage

// ===== rtl/pups_cfg.sv =====
// Configuration register file of the profile unlock prefetch sequencer.
module pups_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  output pups_pkg::cfg_t    cfg_o
);
  import pups_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNLOCK_WAIT:   cfg_d.unlock_wait   = cfg_wdata_i;
        REG_PF_INTERVAL:   cfg_d.pf_interval   = cfg_wdata_i;
        REG_RESEND_DELAY:  cfg_d.resend_delay  = cfg_wdata_i;
        REG_POLL_DELAY:    cfg_d.poll_delay    = cfg_wdata_i;
        REG_POLL_INTERVAL: cfg_d.poll_interval = cfg_wdata_i;
        REG_REFETCH_DELAY: cfg_d.refetch_delay = cfg_wdata_i;
        REG_PATHS:         cfg_d.paths         = cfg_wdata_i[1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/pups_engine.sv =====
// Input register, sequencer state and the single-pass command evaluation.
module pups_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pups_pkg::in_beat_t  in_beat_i,
  input  pups_pkg::cfg_t      cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output pups_pkg::bundle_t   bundle_o
);
  import pups_pkg::*;

  logic       in_vld_q, in_vld_d;
  in_beat_t   in_q;
  seq_state_t st_q, st_d;
  logic       accept, adv;

  logic [19:0] poll_off;
  logic [31:0] resend_dl, poll_dl, refetch_dl;
  logic        due_unlock, due_pf, due_resend, due_poll, due_refetch;

  assign adv        = in_vld_q & ~full_i;
  assign in_stall_o = in_vld_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_vld_d   = accept | (in_vld_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_beat_i;
    end
  end

  // Post-save deadlines are relative to the stamp of the profile write.
  assign poll_off    = 20'(cfg_i.poll_interval) * 20'(st_q.ps_round - 4'd1);
  assign resend_dl   = st_q.ps_start + 32'(cfg_i.resend_delay);
  assign poll_dl     = st_q.ps_start + 32'(cfg_i.poll_delay) + 32'(poll_off);
  assign refetch_dl  = st_q.ps_start + 32'(cfg_i.refetch_delay);
  assign due_unlock  = is_due(in_q.now, st_q.unlock_dl);
  assign due_pf      = is_due(in_q.now, st_q.pf_dl);
  assign due_resend  = is_due(in_q.now, resend_dl);
  assign due_poll    = is_due(in_q.now, poll_dl);
  assign due_refetch = is_due(in_q.now, refetch_dl);

  always_comb begin
    logic [1:0]      n;
    logic            done;
    logic [2:0][1:0] act;
    logic [2:0][7:0] rid;
    logic            nak;

    st_d = st_q;
    n    = 2'd0;
    done = 1'b0;
    act  = '0;
    rid  = '0;
    nak  = 1'b0;

    case (in_q.command)
      CMD_SEEN: begin
        if (in_q.report_len != 8'd0) begin
          if (in_q.rpt_id == HANDSHAKE_RPT_ID) begin
            st_d.hs_valid = (in_q.report_len >= HANDSHAKE_LEN);
          end
          if (in_q.rpt_id == PROF_FIRST && !st_q.edge_flag) begin
            st_d.edge_flag      = 1'b1;
            st_d.ready_flag     = 1'b0;
            st_d.unlock_armed   = 1'b1;
            st_d.unlock_wait    = 1'b0;
            st_d.pf_active      = 1'b0;
            st_d.pf_marks       = 1'b0;
            st_d.ps_active      = 1'b0;
            st_d.ps_round       = 4'd0;
          end
        end
      end
      CMD_SET: begin
        if (in_q.rpt_id >= WRITE_FIRST && in_q.rpt_id <= WRITE_LAST &&
            st_q.edge_flag) begin
          st_d.ps_active = 1'b1;
          st_d.ps_round  = 4'd0;
          st_d.ps_start  = in_q.now;
        end
      end
      CMD_TICK: begin
        // Each stage either completes and ends the tick or falls through.
        if (st_q.unlock_armed && st_q.hs_valid && cfg_i.paths[0]) begin
          act[0] = ACT_HANDSHAKE;
          n      = 2'd1;
          if (in_q.transfer_ok[0]) begin
            act[1] = ACT_UNLOCK;
            n      = 2'd2;
            if (in_q.transfer_ok[1]) begin
              st_d.unlock_armed   = 1'b0;
              st_d.unlock_wait    = 1'b1;
              st_d.unlock_dl      = in_q.now + 32'(cfg_i.unlock_wait);
              done                = 1'b1;
            end
          end
        end
        if (!done && st_q.unlock_wait && due_unlock) begin
          st_d.unlock_wait = 1'b0;
          st_d.pf_active   = 1'b1;
          st_d.pf_marks    = 1'b1;
          st_d.pf_next_id  = PROF_FIRST;
          st_d.pf_dl       = in_q.now;
          done             = 1'b1;
        end
        if (!done && st_q.pf_active && due_pf && cfg_i.paths[1] && n != 2'd3) begin
          act[n] = ACT_REQUEST;
          rid[n] = st_q.pf_next_id;
          if (in_q.transfer_ok[n]) begin
            done = 1'b1;
            if (st_q.pf_next_id >= PROF_LAST) begin
              st_d.pf_active = 1'b0;
              st_d.pf_marks  = 1'b0;
              if (st_q.pf_marks) begin
                st_d.ready_flag = 1'b1;
              end
            end else begin
              st_d.pf_next_id = st_q.pf_next_id + 8'd1;
              st_d.pf_dl      = in_q.now + 32'(cfg_i.pf_interval);
            end
          end
          n = n + 2'd1;
        end
        if (!done && st_q.ps_active && st_q.edge_flag) begin
          if (st_q.ps_round == 4'd0 && due_resend && cfg_i.paths[0]) begin
            if (n != 2'd3) begin
              act[n] = ACT_UNLOCK;
              if (in_q.transfer_ok[n]) begin
                st_d.ps_round = 4'd1;
              end
              n = n + 2'd1;
            end
          end else if (st_q.ps_round >= 4'd1 && st_q.ps_round <= STATUS_POLLS &&
                       due_poll && cfg_i.paths[1]) begin
            if (n != 2'd3) begin
              act[n] = ACT_REQUEST;
              rid[n] = STATUS_ID;
              if (in_q.transfer_ok[n]) begin
                st_d.ps_round = st_q.ps_round + 4'd1;
              end
              n = n + 2'd1;
            end
          end else if (st_q.ps_round == ROUND_REFETCH && due_refetch) begin
            st_d.pf_active  = 1'b1;
            st_d.pf_marks   = 1'b0;
            st_d.pf_next_id = PROF_FIRST;
            st_d.pf_dl      = in_q.now;
            st_d.ps_round   = ROUND_END;
            st_d.ps_active  = 1'b0;
          end
        end
      end
      CMD_RESET: begin
        st_d = STATE_RESET;
      end
      CMD_QUERY: begin
        nak = (in_q.rpt_id >= PROF_FIRST) && (in_q.rpt_id <= PROF_LAST) &&
              st_q.edge_flag && !st_q.ready_flag;
      end
      default: begin
        st_d = st_q;
      end
    endcase

    if (n == 2'd0) begin
      n = 2'd1;
    end

    bundle_o.count          = n;
    bundle_o.action         = act;
    bundle_o.request_id     = rid;
    bundle_o.edge_detected  = st_d.edge_flag;
    bundle_o.snap_ready     = st_d.ready_flag;
    bundle_o.nak_profile    = nak;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  assign push_o = adv;

  ap_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_vld_q && $stable(in_q))
    else $error("held item lost while stalled");
  ap_pending_excl_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.unlock_armed && st_q.unlock_wait))
    else $error("unlock armed and unlock wait both set");
  ap_state_only_on_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(adv) |-> $stable(st_q))
    else $error("sequencer state changed without an item");

endmodule

// ===== rtl/pups_out.sv =====
// Two-bundle result buffer that hands out one result beat per cycle while not stalled.
module pups_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pups_pkg::bundle_t   bundle_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pups_pkg::out_beat_t out_beat_o
);
  import pups_pkg::*;

  bundle_t    bun_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  bundle_t    head;
  logic       last, take, pop;

  assign head        = bun_q[rd_q];
  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign last        = (idx_q == head.count - 2'd1);
  assign take        = out_valid_o & ~out_stall_i;
  assign pop         = take & last;

  assign out_beat_o.action         = head.action[idx_q];
  assign out_beat_o.request_id     = head.request_id[idx_q];
  assign out_beat_o.edge_detected  = head.edge_detected;
  assign out_beat_o.snap_ready     = head.snap_ready;
  assign out_beat_o.nak_profile    = head.nak_profile;
  assign out_beat_o.last           = last;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
    idx_d = pop ? 2'd0 : (take ? idx_q + 2'd1 : idx_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      bun_q[wr_q] <= bundle_i;
    end
  end

  ap_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd3) && !(push_i && full_o))
    else $error("result buffer overflow");
  ap_beat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < head.count) && (head.count != 2'd0))
    else $error("beat index beyond bundle");
  ap_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("buffer count out of step with pops");

endmodule

// ===== rtl/profile_unlock_prefetch_sequencer_top.sv =====
// Top level of the profile unlock prefetch sequencer.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+-------------------------------------
//   input   | in_valid_i / in_stall_o    | in_beat_i  (command, id, len, now, ok)
//   result  | out_valid_o / out_stall_i  | out_beat_o (action, id, flags, last)
//   config  | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// An accepted item is evaluated in one pass from the input register; its results are
// registered in the result buffer. A tick gives up to three beats, all else one beat.
// One item can be accepted per cycle unless the input stalls; the result port, at one
// beat per cycle unless stalled, sets the sustained rate in result beats.
// Reset is asynchronous and restores state and registers at once; no sweep follows.
// A two-bundle result buffer absorbs output stalls; input stalls only when it is full.
module profile_unlock_prefetch_sequencer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pups_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pups_pkg::out_beat_t out_beat_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);
  import pups_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    push, full;

  pups_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  pups_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_beat_i (in_beat_i),
    .cfg_i     (cfg),
    .full_i    (full),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  pups_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .bundle_i   (bundle),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the profile unlock prefetch sequencer: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pups_pkg::*;

  // Commands 5 to 7 have no meaning; the block must answer them with a quiet beat.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 50;
  localparam int PHASES       = 6;
  localparam int PRINT_CAP    = 100;

  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_beat_t    in_beat   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_beat;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = REG_UNLOCK_WAIT;
  logic [15:0] cfg_wdata = '0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  // Settings of the predictor, mirroring what has been written to the block.
  logic [15:0] cfg_unlock_wait, cfg_pf_interval, cfg_resend, cfg_poll_delay;
  logic [15:0] cfg_poll_interval, cfg_refetch;
  logic [1:0]  cfg_paths;

  // Sequencer state as the predictor sees it.
  logic        seen_edge, snap_ready, hs_ok, unlock_armed, unlock_waiting;
  logic [31:0] unlock_due_at, pf_due_at, ps_origin;
  logic        pf_running, pf_sets_ready, ps_running;
  logic [7:0]  pf_id;
  logic [3:0]  ps_round;

  // Transfers issued by the tick under evaluation.
  logic [1:0]  xfer_act [3];
  logic [7:0]  xfer_id  [3];
  int          xfer_n;
  logic [2:0]  xfer_ok;

  out_beat_t   model_beats [$];
  out_beat_t   pending_beats [$];
  logic        row_typed = 1'b0;
  out_beat_t   row_want  = '0;
  int          mismatches = 0;
  logic        calm = 1'b0;
  logic [31:0] clock_now = '0;

  always #1 clk = ~clk;

  profile_unlock_prefetch_sequencer_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void clear_state();
    seen_edge      = 1'b0;
    snap_ready     = 1'b1;
    hs_ok          = 1'b0;
    unlock_armed   = 1'b0;
    unlock_waiting = 1'b0;
    unlock_due_at  = '0;
    pf_running     = 1'b0;
    pf_sets_ready  = 1'b0;
    pf_id          = PROF_FIRST;
    pf_due_at      = '0;
    ps_running     = 1'b0;
    ps_round       = '0;
    ps_origin      = '0;
  endfunction

  // A deadline counts as reached once the wrapped difference is not negative.
  function automatic bit reached(logic [31:0] now, logic [31:0] mark);
    logic [31:0] gap;
    gap = now - mark;
    return !gap[31];
  endfunction

  function automatic bit slot_free();
    return xfer_n < 3;
  endfunction

  function automatic bit launch(logic [1:0] act, logic [7:0] id);
    xfer_act[xfer_n] = act;
    xfer_id[xfer_n]  = id;
    xfer_n++;
    return xfer_ok[xfer_n - 1];
  endfunction

  function automatic void begin_snapshot(logic [31:0] now, logic marks);
    pf_running    = 1'b1;
    pf_sets_ready = marks;
    pf_id         = PROF_FIRST;
    pf_due_at     = now;
  endfunction

  function automatic bit try_unlock(logic [31:0] now);
    if (!unlock_armed || !hs_ok || !cfg_paths[0] || !slot_free()) return 1'b0;
    if (!launch(ACT_HANDSHAKE, 8'h00)) return 1'b0;
    if (!slot_free() || !launch(ACT_UNLOCK, 8'h00)) return 1'b0;
    unlock_armed   = 1'b0;
    unlock_waiting = 1'b1;
    unlock_due_at  = now + {16'h0, cfg_unlock_wait};
    return 1'b1;
  endfunction

  function automatic bit try_wait(logic [31:0] now);
    if (!unlock_waiting || !reached(now, unlock_due_at)) return 1'b0;
    unlock_waiting = 1'b0;
    begin_snapshot(now, 1'b1);
    return 1'b1;
  endfunction

  function automatic bit try_prefetch(logic [31:0] now);
    logic [7:0] id;
    id = pf_id;
    if (!pf_running || !reached(now, pf_due_at) || !cfg_paths[1] || !slot_free()) return 1'b0;
    if (!launch(ACT_REQUEST, id)) return 1'b0;
    if (id >= PROF_LAST) begin
      pf_running = 1'b0;
      if (pf_sets_ready) snap_ready = 1'b1;
      pf_sets_ready = 1'b0;
    end else begin
      pf_id     = id + 8'd1;
      pf_due_at = now + {16'h0, cfg_pf_interval};
    end
    return 1'b1;
  endfunction

  function automatic void try_post_save(logic [31:0] now);
    logic [31:0] poll_at;
    if (!ps_running || !seen_edge) return;
    poll_at = ps_origin + {16'h0, cfg_poll_delay}
            + {16'h0, cfg_poll_interval} * ({28'h0, ps_round} - 32'd1);
    if (ps_round == 4'd0 && reached(now, ps_origin + {16'h0, cfg_resend}) && cfg_paths[0]) begin
      if (slot_free() && launch(ACT_UNLOCK, 8'h00)) ps_round = 4'd1;
      return;
    end
    if (ps_round >= 4'd1 && ps_round <= STATUS_POLLS && reached(now, poll_at) &&
        cfg_paths[1]) begin
      if (slot_free() && launch(ACT_REQUEST, STATUS_ID)) ps_round = ps_round + 4'd1;
      return;
    end
    if (ps_round == STATUS_POLLS + 4'd1 && reached(now, ps_origin + {16'h0, cfg_refetch})) begin
      begin_snapshot(now, 1'b0);
      ps_round   = STATUS_POLLS + 4'd2;
      ps_running = 1'b0;
    end
  endfunction

  // Works out the result beats of one item and leaves them in model_beats.
  function automatic void predict_sequencer(in_beat_t b);
    logic      nak;
    out_beat_t beat;
    nak     = 1'b0;
    xfer_n  = 0;
    xfer_ok = b.transfer_ok;
    case (b.command)
      CMD_SEEN: begin
        if (b.report_len != 8'd0) begin
          if (b.rpt_id == HANDSHAKE_RPT_ID) hs_ok = b.report_len >= HANDSHAKE_LEN;
          if (b.rpt_id == PROF_FIRST && !seen_edge) begin
            seen_edge      = 1'b1;
            snap_ready     = 1'b0;
            unlock_armed   = 1'b1;
            unlock_waiting = 1'b0;
            pf_running     = 1'b0;
            pf_sets_ready  = 1'b0;
            ps_running     = 1'b0;
            ps_round       = 4'd0;
          end
        end
      end
      CMD_SET: begin
        if (b.rpt_id >= WRITE_FIRST && b.rpt_id <= WRITE_LAST && seen_edge) begin
          ps_running = 1'b1;
          ps_round   = 4'd0;
          ps_origin  = b.now;
        end
      end
      CMD_TICK: begin
        // A stage that does not complete hands the tick on to the next one.
        if (!try_unlock(b.now)) begin
          if (!try_wait(b.now)) begin
            if (!try_prefetch(b.now)) try_post_save(b.now);
          end
        end
      end
      CMD_RESET: clear_state();
      CMD_QUERY: begin
        nak = b.rpt_id >= PROF_FIRST && b.rpt_id <= PROF_LAST && seen_edge && !snap_ready;
      end
      default: ;
    endcase
    if (xfer_n == 0) begin
      xfer_act[0] = ACT_NONE;
      xfer_id[0]  = 8'h00;
      xfer_n      = 1;
    end
    model_beats.delete();
    for (int k = 0; k < xfer_n; k++) begin
      beat.action         = xfer_act[k];
      beat.request_id     = (xfer_act[k] == ACT_REQUEST) ? xfer_id[k] : 8'h00;
      beat.edge_detected  = seen_edge;
      beat.snap_ready     = snap_ready;
      beat.nak_profile    = nak;
      beat.last           = (k == xfer_n - 1);
      model_beats.push_back(beat);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    if (in_fire) begin
      predict_sequencer(in_beat);
      if (row_typed) begin
        pending_beats.push_back(row_want);
      end else begin
        foreach (model_beats[k]) pending_beats.push_back(model_beats[k]);
      end
    end
    if (out_fire) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("result beat %h with nothing outstanding", out_beat));
      end else begin
        want = pending_beats.pop_front();
        check_field("action", out_beat.action, want.action);
        check_field("request_id", out_beat.request_id, want.request_id);
        check_field("edge_detected", out_beat.edge_detected, want.edge_detected);
        check_field("snap_ready", out_beat.snap_ready, want.snap_ready);
        check_field("nak_profile", out_beat.nak_profile, want.nak_profile);
        check_field("last", out_beat.last, want.last);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  initial begin : result_backpressure
    int run;
    forever begin
      run = $urandom_range(1, 30);
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (run) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_item(in_beat_t b, logic typed, out_beat_t want);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!in_fire) @(posedge clk);
  endtask

  function automatic in_beat_t make_beat(logic [2:0] cmd, logic [7:0] id, logic [7:0] len,
                                         logic [31:0] now, logic [2:0] ok);
    in_beat_t b;
    b.command     = cmd;
    b.rpt_id      = id;
    b.report_len  = len;
    b.now         = now;
    b.transfer_ok = ok;
    return b;
  endfunction

  task automatic send_random(logic [2:0] cmd, logic [7:0] id, logic [7:0] len, logic [31:0] now,
                             logic [2:0] ok);
    send_item(make_beat(cmd, id, len, now, ok), 1'b0, '0);
  endtask

  // Stops the sender, lets every outstanding beat come back and then lets the pipeline settle.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0 && waited < QUIET_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic poke(reg_idx_e idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_UNLOCK_WAIT:   cfg_unlock_wait   = value;
      REG_PF_INTERVAL:   cfg_pf_interval   = value;
      REG_RESEND_DELAY:  cfg_resend        = value;
      REG_POLL_DELAY:    cfg_poll_delay    = value;
      REG_POLL_INTERVAL: cfg_poll_interval = value;
      REG_REFETCH_DELAY: cfg_refetch       = value;
      REG_PATHS:         cfg_paths         = value[1:0];
      default: ;
    endcase
  endtask

  task automatic write_config(cfg_t c);
    wait_drained();
    poke(REG_UNLOCK_WAIT, c.unlock_wait);
    poke(REG_PF_INTERVAL, c.pf_interval);
    poke(REG_RESEND_DELAY, c.resend_delay);
    poke(REG_POLL_DELAY, c.poll_delay);
    poke(REG_POLL_INTERVAL, c.poll_interval);
    poke(REG_REFETCH_DELAY, c.refetch_delay);
    // The upper bits of the path register are written with noise; only two bits count.
    poke(REG_PATHS, {14'($urandom_range(0, 16383)), c.paths});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [2:0] pick_ok();
    return ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
  endfunction

  // Reset, a handshake report (now and then too short) and the first profile report: the start of every session.
  task automatic open_session();
    send_random(CMD_RESET, 8'($urandom), 8'($urandom), clock_now, pick_ok());
    send_random(CMD_SEEN, HANDSHAKE_RPT_ID,
                ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 60)) :
                                              8'($urandom_range(61, 255)),
                clock_now, pick_ok());
    send_random(CMD_SEEN, PROF_FIRST, 8'($urandom_range(1, 255)), clock_now, pick_ok());
  endtask

  task automatic random_phase(int step_cap);
    int r;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      calm = (n < 12);
      r = $urandom_range(0, 99);
      if (n == 0 || r < 3) begin
        open_session();
      end else if (r < 5) begin
        send_random(CMD_RESET, 8'($urandom), 8'($urandom), clock_now, pick_ok());
      end else if (r < 9) begin
        send_random(CMD_SEEN, HANDSHAKE_RPT_ID, 8'($urandom), clock_now, pick_ok());
      end else if (r < 12) begin
        send_random(CMD_SEEN, PROF_FIRST, ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                    clock_now, pick_ok());
      end else if (r < 20) begin
        send_random(CMD_QUERY, 8'h6E + 8'($urandom_range(0, 15)), 8'($urandom), 32'($urandom),
                    pick_ok());
      end else if (r < 24 || (r < 40 && seen_edge && !unlock_armed && !unlock_waiting &&
                              !pf_running && !ps_running)) begin
        send_random(CMD_SET, 8'h5F + 8'($urandom_range(0, 4)), 8'($urandom), clock_now,
                    pick_ok());
      end else if (r < 30) begin
        send_random(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 32'($urandom),
                    3'($urandom_range(0, 7)));
      end else begin
        // Now and then the clock jumps by about half its range to probe the wrapped compare.
        if ($urandom_range(0, 49) == 0) clock_now += 32'h7FFF_0000 + $urandom_range(0, 32'h1FFFF);
        else clock_now += $urandom_range(0, step_cap);
        send_random(CMD_TICK, 8'($urandom), 8'($urandom), clock_now, pick_ok());
      end
    end
    calm = 1'b0;
  endtask

  function automatic out_beat_t quiet_result(logic edge_seen, logic ready, logic nak);
    out_beat_t b;
    b.action         = ACT_NONE;
    b.request_id     = 8'h00;
    b.edge_detected  = edge_seen;
    b.snap_ready     = ready;
    b.nak_profile    = nak;
    b.last           = 1'b1;
    return b;
  endfunction

  function automatic row_t row(logic [2:0] cmd, logic [7:0] id, logic [7:0] len,
                               logic [31:0] now, logic [2:0] ok, logic typed, out_beat_t want);
    row_t t;
    t.beat  = make_beat(cmd, id, len, now, ok);
    t.typed = typed;
    t.want  = want;
    return t;
  endfunction

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (in_fire || out_fire) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    row_t    script [$];
    cfg_t    c;
    int      step_cap;
    cfg_unlock_wait   = 16'd4000;
    cfg_pf_interval   = 16'd80;
    cfg_resend        = 16'd500;
    cfg_poll_delay    = 16'd1000;
    cfg_poll_interval = 16'd250;
    cfg_refetch       = 16'd5500;
    cfg_paths         = 2'd3;
    clear_state();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings.
    script.push_back(row(CMD_QUERY, PROF_FIRST, 8'd0, 32'd0, 3'b000, 1, quiet_result(0, 1, 0)));
    script.push_back(row(CMD_SPARE_LO, 8'h20, 8'h40, 32'h1234, 3'b111, 1,
                         quiet_result(0, 1, 0)));
    script.push_back(row(CMD_SPARE_HI, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 3'b111, 1,
                         quiet_result(0, 1, 0)));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd0, 3'b000, 1, quiet_result(0, 1, 0)));
    // Handshake report one byte short of valid.
    script.push_back(row(CMD_SEEN, HANDSHAKE_RPT_ID, HANDSHAKE_LEN - 8'd1, 32'd0, 3'b111, 0, '0));
    // A zero length report is ignored.
    script.push_back(row(CMD_SEEN, PROF_FIRST, 8'd0, 32'd0, 3'b000, 1, quiet_result(0, 1, 0)));
    script.push_back(row(CMD_SEEN, PROF_FIRST, 8'd1, 32'd0, 3'b000, 1, quiet_result(1, 0, 0)));
    script.push_back(row(CMD_QUERY, PROF_FIRST, 8'd0, 32'd0, 3'b000, 1, quiet_result(1, 0, 1)));
    script.push_back(row(CMD_QUERY, PROF_LAST, 8'd0, 32'd0, 3'b000, 1, quiet_result(1, 0, 1)));
    script.push_back(row(CMD_QUERY, PROF_FIRST - 8'd1, 8'd0, 32'd0, 3'b000, 1,
                         quiet_result(1, 0, 0)));
    script.push_back(row(CMD_QUERY, PROF_LAST + 8'd1, 8'd0, 32'd0, 3'b000, 1,
                         quiet_result(1, 0, 0)));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd10, 3'b111, 0, '0));
    script.push_back(row(CMD_SEEN, HANDSHAKE_RPT_ID, HANDSHAKE_LEN, 32'd0, 3'b111, 0, '0));
    // Failed handshake, then failed unlock: both fall through to the later stages.
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd20, 3'b110, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd30, 3'b101, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd40, 3'b111, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd4039, 3'b111, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd4040, 3'b111, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd4040, 3'b111, 0, '0));
    script.push_back(row(CMD_SET, WRITE_FIRST, 8'h00, 32'd4100, 3'b000, 0, '0));
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'd4120, 3'b000, 0, '0));
    // Half a wrap past the prefetch deadline: it is not due, but the earlier resend deadline is.
    script.push_back(row(CMD_TICK, 8'h00, 8'h00, 32'h8000_0000 + 32'd4120, 3'b111, 0, '0));
    script.push_back(row(CMD_SEEN, HANDSHAKE_RPT_ID, 8'hFF, 32'd0, 3'b111, 0, '0));
    script.push_back(row(CMD_RESET, 8'h00, 8'h00, 32'd0, 3'b000, 1, quiet_result(0, 1, 0)));
    // A profile write before any extended controller is seen does nothing.
    script.push_back(row(CMD_SET, WRITE_LAST, 8'h00, 32'd0, 3'b000, 1, quiet_result(0, 1, 0)));
    foreach (script[i]) send_item(script[i].beat, script[i].typed, script[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       c = '{default: 16'h0000, paths: 2'd3};
        1:       c = '{default: 16'hFFFF, paths: 2'd3};
        default: begin
          c.unlock_wait   = 16'($urandom_range(0, 400));
          c.pf_interval   = 16'($urandom_range(0, 400));
          c.resend_delay  = 16'($urandom_range(0, 400));
          c.poll_delay    = 16'($urandom_range(0, 400));
          c.poll_interval = 16'($urandom_range(0, 400));
          c.refetch_delay = 16'($urandom_range(0, 400));
          c.paths         = (phase == 2) ? 2'd1 : (phase == 3) ? 2'd2 :
                            (phase == 4) ? 2'd0 : 2'($urandom_range(0, 3));
        end
      endcase
      write_config(c);
      step_cap = c.unlock_wait;
      if (c.pf_interval > step_cap) step_cap = c.pf_interval;
      if (c.refetch_delay > step_cap) step_cap = c.refetch_delay;
      if (c.poll_delay + c.poll_interval > step_cap) step_cap = c.poll_delay + c.poll_interval;
      step_cap = step_cap / 3 + 2;
      random_phase(step_cap);
    end

    wait_drained();
    if (pending_beats.size() != 0)
      flag_mismatch($sformatf("%0d result beats never arrived", pending_beats.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
